// ===== hdl/wsfp_pkg.sv =====
// ----------------------------------------------------------------------------
// wsfp_pkg
// Shared types and constants for the WebSocket frame parser.
// ----------------------------------------------------------------------------
package wsfp_pkg;

   // Default width of the decoded frame length.
   localparam int LENGTH_BITS_DEF = 32;

   localparam int BYTE_BITS   = 8;
   localparam int OUT_LEN_BITS = 32;

   // Result kinds.
   localparam logic KIND_HEADER = 1'b0;
   localparam logic KIND_DATA   = 1'b1;

   // Header field codes.
   localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
   localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

   typedef struct packed {
      logic                    kind;
      logic                    fin;
      logic [2:0]              rsv;
      logic [3:0]              opcode;
      logic                    masked;
      logic [OUT_LEN_BITS-1:0] frame_bytes;
      logic [BYTE_BITS-1:0]    data;
      logic                    last;
   } result_type;

endpackage

// ===== hdl/wsfp_in_stage.sv =====
// ----------------------------------------------------------------------------
// wsfp_in_stage
// Input register for the received byte stream.
// ----------------------------------------------------------------------------
module wsfp_in_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [wsfp_pkg::BYTE_BITS-1:0] req_tdata,
   output logic                          byte_valid,
   output logic [wsfp_pkg::BYTE_BITS-1:0] byte_data,
   input  logic                          byte_take
);

   logic                           valid_ff;
   logic                           valid_in;
   logic [wsfp_pkg::BYTE_BITS-1:0] byte_ff;

   // The register can load whenever it is empty or its byte leaves this cycle.
   assign req_tready = !valid_ff || byte_take;
   assign valid_in   = req_tready ? req_tvalid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_tready && req_tvalid) begin
         byte_ff <= req_tdata;
      end
   end

   assign byte_valid = valid_ff;
   assign byte_data  = byte_ff;

endmodule

// ===== hdl/wsfp_parser.sv =====
// ----------------------------------------------------------------------------
// wsfp_parser
// Frame header decoder, length and key collection, and payload unmasking.
// ----------------------------------------------------------------------------
module wsfp_parser #(
   parameter int LENGTH_BITS = wsfp_pkg::LENGTH_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           byte_valid,
   input  logic [wsfp_pkg::BYTE_BITS-1:0] byte_data,
   output logic                           byte_take,
   input  logic                           slot_free,
   output logic                           res_valid,
   output wsfp_pkg::result_type           result
);

   typedef enum logic [2:0] {
      PH_HDR0,
      PH_HDR1,
      PH_EXT16,
      PH_EXT64,
      PH_KEY,
      PH_DATA
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [8:0]             hdr_ff, hdr_in;
   logic [3:0]             count_ff, count_in;
   logic [LENGTH_BITS-1:0] flen_ff, flen_in;
   logic [31:0]            key_ff, key_in;
   logic [LENGTH_BITS-1:0] rem_ff, rem_in;
   logic [1:0]             kidx_ff, kidx_in;

   logic                   produces;
   logic                   finish;
   logic                   last_hdr;
   logic [7:0]             key_byte;
   wsfp_pkg::result_type   res;

   assign key_byte = 8'(key_ff >> {kidx_ff, 3'b000});

   always_comb begin
      phase_in = phase_ff;
      hdr_in   = hdr_ff;
      count_in = count_ff;
      flen_in  = flen_ff;
      key_in   = key_ff;
      rem_in   = rem_ff;
      kidx_in  = kidx_ff;
      produces = 1'b0;
      finish   = 1'b0;
      res      = '0;

      case (phase_ff)
         PH_HDR0: begin
            hdr_in   = {byte_data[7], byte_data[6:4], byte_data[3:0], 1'b0};
            key_in   = '0;
            flen_in  = '0;
            count_in = '0;
            phase_in = PH_HDR1;
         end
         PH_HDR1: begin
            hdr_in   = {hdr_ff[8:1], byte_data[7]};
            count_in = '0;
            if (byte_data[6:0] == wsfp_pkg::LEN_CODE_EXT16) begin
               flen_in  = '0;
               phase_in = PH_EXT16;
            end else if (byte_data[6:0] == wsfp_pkg::LEN_CODE_EXT64) begin
               flen_in  = '0;
               phase_in = PH_EXT64;
            end else begin
               flen_in = LENGTH_BITS'(byte_data[6:0]);
               if (byte_data[7]) begin
                  phase_in = PH_KEY;
               end else begin
                  finish = 1'b1;
               end
            end
         end
         PH_EXT16: begin
            flen_in  = LENGTH_BITS'({flen_ff[7:0], byte_data});
            count_in = 4'(count_ff + 4'd1);
            if (count_in >= 4'd2) begin
               count_in = '0;
               if (hdr_ff[0]) begin
                  phase_in = PH_KEY;
               end else begin
                  finish = 1'b1;
               end
            end
         end
         PH_EXT64: begin
            // Bytes above the kept length width fall off the top.
            flen_in  = {flen_ff[LENGTH_BITS-9:0], byte_data};
            count_in = 4'(count_ff + 4'd1);
            if (count_in >= 4'd8) begin
               count_in = '0;
               if (hdr_ff[0]) begin
                  phase_in = PH_KEY;
               end else begin
                  finish = 1'b1;
               end
            end
         end
         PH_KEY: begin
            key_in   = key_ff | (32'(byte_data) << {count_ff[1:0], 3'b000});
            count_in = 4'(count_ff + 4'd1);
            if (count_in >= 4'd4) begin
               count_in = '0;
               finish   = 1'b1;
            end
         end
         PH_DATA: begin
            produces        = 1'b1;
            kidx_in         = 2'(kidx_ff + 2'd1);
            rem_in          = rem_ff - LENGTH_BITS'(1);
            res.kind        = wsfp_pkg::KIND_DATA;
            res.fin         = hdr_ff[8];
            res.rsv         = hdr_ff[7:5];
            res.opcode      = hdr_ff[4:1];
            res.masked      = hdr_ff[0];
            res.frame_bytes = wsfp_pkg::OUT_LEN_BITS'(flen_ff);
            res.data        = byte_data ^ key_byte;
            res.last        = (rem_in == '0);
            if (rem_in == '0) begin
               phase_in = PH_HDR0;
            end
         end
         default: begin
            phase_in = PH_HDR0;
         end
      endcase

      // Header complete: emit the header result and arm the payload count.
      last_hdr = (flen_in == '0);
      if (finish) begin
         produces        = 1'b1;
         kidx_in         = '0;
         rem_in          = flen_in;
         phase_in        = last_hdr ? PH_HDR0 : PH_DATA;
         res.kind        = wsfp_pkg::KIND_HEADER;
         res.fin         = hdr_in[8];
         res.rsv         = hdr_in[7:5];
         res.opcode      = hdr_in[4:1];
         res.masked      = hdr_in[0];
         res.frame_bytes = wsfp_pkg::OUT_LEN_BITS'(flen_in);
         res.data        = '0;
         res.last        = last_hdr;
      end
   end

   // A byte that makes a result waits until the output register has room.
   assign byte_take = byte_valid && (!produces || slot_free);
   assign res_valid = byte_take && produces;
   assign result    = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR0;
         hdr_ff   <= '0;
         count_ff <= '0;
         flen_ff  <= '0;
         key_ff   <= '0;
         rem_ff   <= '0;
         kidx_ff  <= '0;
      end else if (byte_take) begin
         phase_ff <= phase_in;
         hdr_ff   <= hdr_in;
         count_ff <= count_in;
         flen_ff  <= flen_in;
         key_ff   <= key_in;
         rem_ff   <= rem_in;
         kidx_ff  <= kidx_in;
      end
   end

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      res_valid && result.last |=> phase_ff == PH_HDR0)
      else $error("frame did not restart after its last result");

   a_data_emits: assert property (@(posedge clock) disable iff (reset)
      byte_take && phase_ff == PH_DATA |-> res_valid && result.kind == wsfp_pkg::KIND_DATA)
      else $error("payload byte taken without a data result");

   a_header_data_zero: assert property (@(posedge clock) disable iff (reset)
      res_valid && result.kind == wsfp_pkg::KIND_HEADER |-> result.data == 8'd0)
      else $error("header result carries nonzero data");

   a_remaining_live: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> rem_ff != '0)
      else $error("payload phase with no bytes remaining");

endmodule

// ===== hdl/wsfp_out_stage.sv =====
// ----------------------------------------------------------------------------
// wsfp_out_stage
// Result register and response stream packing.
// ----------------------------------------------------------------------------
module wsfp_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 res_valid,
   input  wsfp_pkg::result_type result,
   output logic                 slot_free,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // Fields from bit 0 up: fin, rsv[2:0], opcode[3:0], masked,
   // frame_bytes[31:0], data[7:0], zero fill.
   output logic [55:0]          rsp_tdata,
   output logic                 rsp_tlast,
   // Fields from bit 0 up: kind.
   output logic [0:0]           rsp_tuser
);

   logic                 valid_ff;
   logic                 valid_in;
   wsfp_pkg::result_type res_ff;

   assign slot_free = !valid_ff || rsp_tready;
   assign valid_in  = slot_free ? res_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (slot_free && res_valid) begin
         res_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {7'd0, res_ff.data, res_ff.frame_bytes, res_ff.masked,
                        res_ff.opcode, res_ff.rsv, res_ff.fin};
   assign rsp_tlast  = res_ff.last;
   assign rsp_tuser  = res_ff.kind;

endmodule

// ===== hdl/websocket_frame_parser.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_parser
// Splits a received byte stream into WebSocket frames and unmasks payloads.
// ----------------------------------------------------------------------------
// The req_ channel carries one received byte per request. The rsp_ channel
// carries one header result (tuser = 0) when a frame header is complete, then
// one result per payload byte (tuser = 1) with the data unmasked by the key.
// tlast marks the final result of a frame; a zero-length frame has tlast set
// on its header result. Header bytes that do not complete a header give no
// result.
// A byte accepted into the input register is decoded by the combinational
// frame state logic, and its result is loaded into the output register once
// that register has room. The block takes one byte per clock while the
// output register has room; the rate is set by the single decode step
// between the input and output registers.
// When rsp_tready is low the output register holds its result; bytes that
// make no result still pass, and req_tready drops only once a byte that
// needs the output register finds it full.
// Synchronous reset empties both registers and waits for a first header byte.
// ----------------------------------------------------------------------------
module websocket_frame_parser #(
   parameter int LENGTH_BITS = wsfp_pkg::LENGTH_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // Fields from bit 0 up: in_byte[7:0].
   input  logic [7:0]  req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // Fields from bit 0 up: fin, rsv[2:0], opcode[3:0], masked,
   // frame_bytes[31:0], data[7:0], zero fill.
   output logic [55:0] rsp_tdata,
   output logic        rsp_tlast,
   // Fields from bit 0 up: kind.
   output logic [0:0]  rsp_tuser
);

   logic                           byte_valid;
   logic [wsfp_pkg::BYTE_BITS-1:0] byte_data;
   logic                           byte_take;
   logic                           slot_free;
   logic                           res_valid;
   wsfp_pkg::result_type           result;

   wsfp_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .byte_valid (byte_valid),
      .byte_data  (byte_data),
      .byte_take  (byte_take)
   );

   wsfp_parser #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .byte_data  (byte_data),
      .byte_take  (byte_take),
      .slot_free  (slot_free),
      .res_valid  (res_valid),
      .result     (result)
   );

   wsfp_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (res_valid),
      .result     (result),
      .slot_free  (slot_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
